>>> src/erol_pkg.sv
// shared types and constants for the entry ring offset lookup
// no dependencies
`default_nettype none

package erol_pkg;

    localparam int DEPTH       = 16;
    localparam int LEN_BITS    = 16;
    localparam int HANDLE_BITS = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int OFFSET_W    = 20;
    localparam int SLOT_W      = 4;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

endpackage

`default_nettype wire

>>> src/entry_ring_offset_lookup.sv
// entry ring with byte-offset lookup: handle and length memories plus walk fsm
// depends on erol_pkg
// add: result strobe in the cycle after accept, busy never raised, next beat may follow at once
// find: result in the cycle after accept on an empty ring, else a walk of one entry per cycle; busy until the result
// reset clears write index, read index, full flag and fsm; entry memories are not cleared
// the receiver cannot stall: o_valid marks each result for exactly one cycle
`default_nettype none

module entry_ring_offset_lookup (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_op,
    input  wire logic [erol_pkg::HANDLE_BITS-1:0] i_entry_handle,
    input  wire logic [erol_pkg::LEN_BITS-1:0]    i_entry_size,
    input  wire logic [erol_pkg::OFFSET_W-1:0]    i_char_offset,
    output logic                                 o_valid,
    output logic                                 o_found,
    output logic [erol_pkg::SLOT_W-1:0]           o_slot,
    output logic [erol_pkg::HANDLE_BITS-1:0]      o_found_handle,
    output logic [erol_pkg::LEN_BITS-1:0]         o_found_size,
    output logic [erol_pkg::LEN_BITS-1:0]         o_byte_in_entry,
    output logic                                 o_overwrote
);
    import erol_pkg::*;

    logic [HANDLE_BITS-1:0] handle_mem [DEPTH];
    logic [LEN_BITS-1:0]    len_mem    [DEPTH];

    t_state r_state, n_state;
    logic [IDX_W-1:0]    r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_full, n_full;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [OFFSET_W-1:0] r_before, n_before;
    logic [OFFSET_W-1:0] r_offset;

    logic [HANDLE_BITS-1:0] r_rd_handle;
    logic [LEN_BITS-1:0]    r_rd_len;
    logic [IDX_W-1:0]       rd_addr;

    logic                   r_valid, n_valid;
    logic                   r_found, n_found;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic [HANDLE_BITS-1:0] r_hdl, n_hdl;
    logic [LEN_BITS-1:0]    r_size, n_size;
    logic [LEN_BITS-1:0]    r_bie, n_bie;
    logic                   r_ovw, n_ovw;

    logic                   accept;
    logic                   wr_en;
    logic [OFFSET_W:0]      end_sum;
    logic [OFFSET_W-1:0]    diff;
    logic [IDX_W-1:0]       pos_next;
    logic [IDX_W-1:0]       wr_next;
    logic [IDX_W-1:0]       rd_next;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && (i_op == OP_ADD);

    assign pos_next = next_slot(r_pos);
    assign wr_next  = next_slot(r_wr_idx);
    assign rd_next  = next_slot(r_rd_idx);
    assign end_sum  = {1'b0, r_before} + (OFFSET_W + 1)'(r_rd_len);
    assign diff     = r_offset - r_before;

    // walk issues the next slot while checking the current one
    assign rd_addr = (r_state == ST_WALK) ? pos_next : r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            handle_mem[r_wr_idx] <= i_entry_handle;
            len_mem[r_wr_idx]    <= i_entry_size;
        end
        r_rd_handle <= handle_mem[rd_addr];
        r_rd_len    <= len_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_offset <= i_char_offset;
        end
        r_pos    <= n_pos;
        r_before <= n_before;
        r_found  <= n_found;
        r_slot   <= n_slot;
        r_hdl    <= n_hdl;
        r_size   <= n_size;
        r_bie    <= n_bie;
        r_ovw    <= n_ovw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_full   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_full   <= n_full;
            r_valid  <= n_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_full   = r_full;
        n_pos    = r_pos;
        n_before = r_before;
        n_valid  = 1'b0;
        n_found  = 1'b0;
        n_slot   = '0;
        n_hdl    = '0;
        n_size   = '0;
        n_bie    = '0;
        n_ovw    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_ADD) begin
                        n_valid  = 1'b1;
                        n_wr_idx = wr_next;
                        if (r_full) begin
                            n_rd_idx = rd_next;
                            n_ovw    = 1'b1;
                        end
                        if (wr_next == (r_full ? rd_next : r_rd_idx)) begin
                            n_full = 1'b1;
                        end
                    end else if (!r_full && (r_wr_idx == r_rd_idx)) begin
                        // empty ring: immediate miss
                        n_valid = 1'b1;
                    end else begin
                        n_state  = ST_WALK;
                        n_pos    = r_rd_idx;
                        n_before = '0;
                    end
                end
            end
            ST_WALK: begin
                if ({1'b0, r_offset} < end_sum) begin
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_slot  = SLOT_W'(r_pos);
                    n_hdl   = r_rd_handle;
                    n_size  = r_rd_len;
                    n_bie   = diff[LEN_BITS-1:0];
                    n_state = ST_IDLE;
                end else if (pos_next == r_wr_idx) begin
                    // past the end of the stored bytes
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_before = end_sum[OFFSET_W-1:0];
                    n_pos    = pos_next;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid         = r_valid;
    assign o_found         = r_found;
    assign o_slot          = r_slot;
    assign o_found_handle  = r_hdl;
    assign o_found_size    = r_size;
    assign o_byte_in_entry = r_bie;
    assign o_overwrote     = r_ovw;

endmodule

`default_nettype wire

>>> bench/erol_lookup_checker.sv
`timescale 1ns / 1ps
// result checker for entry_ring_offset_lookup: mirrors the entry ring and compares each result
// depends on erol_pkg; instantiated beside the block by entry_ring_offset_lookup_tb

module erol_lookup_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            i_op,
    input  logic [erol_pkg::HANDLE_BITS-1:0] i_entry_handle,
    input  logic [erol_pkg::LEN_BITS-1:0]    i_entry_size,
    input  logic [erol_pkg::OFFSET_W-1:0]    i_char_offset,
    input  logic                            o_valid,
    input  logic                            o_found,
    input  logic [erol_pkg::SLOT_W-1:0]      o_slot,
    input  logic [erol_pkg::HANDLE_BITS-1:0] o_found_handle,
    input  logic [erol_pkg::LEN_BITS-1:0]    o_found_size,
    input  logic [erol_pkg::LEN_BITS-1:0]    o_byte_in_entry,
    input  logic                            o_overwrote,
    output int                              n_awaited,
    output int                              n_mismatch
);
    import erol_pkg::*;

    typedef struct packed {
        logic                   found;
        logic [SLOT_W-1:0]      slot;
        logic [HANDLE_BITS-1:0] handle;
        logic [LEN_BITS-1:0]    size;
        logic [LEN_BITS-1:0]    byte_off;
        logic                   overwrote;
    } t_lookup_result;

    // mirror of the ring
    logic [HANDLE_BITS-1:0] ring_handle [DEPTH];
    logic [LEN_BITS-1:0]    ring_len    [DEPTH];
    logic [IDX_W-1:0]       wr_idx;
    logic [IDX_W-1:0]       rd_idx;
    logic                   ring_full;

    t_lookup_result awaited_lookups [$];
    int             mismatch_seen = 0;

    initial begin
        n_awaited  = 0;
        n_mismatch = 0;
    end

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // applies one beat to the mirror and returns the result it must produce
    function automatic t_lookup_result compute_ring_result(
        input logic                   op,
        input logic [HANDLE_BITS-1:0] handle,
        input logic [LEN_BITS-1:0]    size,
        input logic [OFFSET_W-1:0]    offset
    );
        t_lookup_result     res;
        logic [IDX_W-1:0]   pos;
        longint unsigned    base;
        int                 steps;
        bit                 done;
        res  = '0;
        base = 0;
        done = 0;
        if (op == OP_ADD) begin
            if (ring_full) begin
                rd_idx        = ring_next(rd_idx);
                res.overwrote = 1'b1;
            end
            ring_handle[wr_idx] = handle;
            ring_len[wr_idx]    = size;
            wr_idx              = ring_next(wr_idx);
            if (wr_idx == rd_idx)
                ring_full = 1'b1;
            return res;
        end
        if (!ring_full && wr_idx == rd_idx)
            return res;
        pos   = rd_idx;
        steps = 0;
        while (!done && steps < DEPTH) begin
            if (longint'(offset) < base + ring_len[pos]) begin
                res.found    = 1'b1;
                res.slot     = SLOT_W'(pos);
                res.handle   = ring_handle[pos];
                res.size     = ring_len[pos];
                res.byte_off = LEN_BITS'(longint'(offset) - base);
                done         = 1;
            end else begin
                base += ring_len[pos];
                pos   = ring_next(pos);
                steps++;
                // walk stops once it wraps around to the write index
                if (pos == wr_idx)
                    done = 1;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: lookup mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_seen++;
    endtask

    always @(posedge i_clk) begin
        t_lookup_result got;
        t_lookup_result want;
        if (!i_rst_n) begin
            wr_idx    = '0;
            rd_idx    = '0;
            ring_full = 1'b0;
            awaited_lookups.delete();
        end else begin
            if (o_valid) begin
                got.found     = o_found;
                got.slot      = o_slot;
                got.handle    = o_found_handle;
                got.size      = o_found_size;
                got.byte_off  = o_byte_in_entry;
                got.overwrote = o_overwrote;
                if (awaited_lookups.size() == 0) begin
                    report_mismatch("result beat with none awaited", 64'(got), '0);
                end else begin
                    want = awaited_lookups.pop_front();
                    if (got.found !== want.found)
                        report_mismatch("found", 64'(got.found), 64'(want.found));
                    if (got.slot !== want.slot)
                        report_mismatch("slot", 64'(got.slot), 64'(want.slot));
                    if (got.handle !== want.handle)
                        report_mismatch("found_handle", 64'(got.handle), 64'(want.handle));
                    if (got.size !== want.size)
                        report_mismatch("found_size", 64'(got.size), 64'(want.size));
                    if (got.byte_off !== want.byte_off)
                        report_mismatch("byte_in_entry", 64'(got.byte_off),
                                        64'(want.byte_off));
                    if (got.overwrote !== want.overwrote)
                        report_mismatch("overwrote", 64'(got.overwrote), 64'(want.overwrote));
                end
            end
            if (start && !busy)
                awaited_lookups.push_back(compute_ring_result(i_op, i_entry_handle,
                                                              i_entry_size, i_char_offset));
        end
        n_awaited  <= awaited_lookups.size();
        n_mismatch <= mismatch_seen;
    end

endmodule

>>> bench/entry_ring_offset_lookup_tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for entry_ring_offset_lookup: directed adds and finds, then random beats
// depends on erol_pkg, entry_ring_offset_lookup and erol_lookup_checker

module entry_ring_offset_lookup_tb;
    import erol_pkg::*;

    localparam int RANDOM_BEATS = 650;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_op;
    logic [HANDLE_BITS-1:0] i_entry_handle;
    logic [LEN_BITS-1:0]    i_entry_size;
    logic [OFFSET_W-1:0]    i_char_offset;
    logic                   o_valid;
    logic                   o_found;
    logic [SLOT_W-1:0]      o_slot;
    logic [HANDLE_BITS-1:0] o_found_handle;
    logic [LEN_BITS-1:0]    o_found_size;
    logic [LEN_BITS-1:0]    o_byte_in_entry;
    logic                   o_overwrote;
    int                     n_awaited;
    int                     n_mismatch;

    // lengths of the live entries, oldest first; only used to aim find offsets
    int live_sizes [$];
    bit allow_gaps = 1;

    entry_ring_offset_lookup uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_entry_handle  (i_entry_handle),
        .i_entry_size    (i_entry_size),
        .i_char_offset   (i_char_offset),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_slot          (o_slot),
        .o_found_handle  (o_found_handle),
        .o_found_size    (o_found_size),
        .o_byte_in_entry (o_byte_in_entry),
        .o_overwrote     (o_overwrote)
    );

    erol_lookup_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_entry_handle  (i_entry_handle),
        .i_entry_size    (i_entry_size),
        .i_char_offset   (i_char_offset),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_slot          (o_slot),
        .o_found_handle  (o_found_handle),
        .o_found_size    (o_found_size),
        .o_byte_in_entry (o_byte_in_entry),
        .o_overwrote     (o_overwrote),
        .n_awaited       (n_awaited),
        .n_mismatch      (n_mismatch)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [LEN_BITS-1:0] pick_entry_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        else if (roll < 70)
            return LEN_BITS'($urandom_range(1, 64));
        else if (roll < 90)
            return LEN_BITS'($urandom_range(65, 4096));
        else if (roll < 95)
            return '1;
        else
            return LEN_BITS'($urandom_range(4097, 65535));
    endfunction

    // mostly offsets inside the live data, some at or past its end
    function automatic logic [OFFSET_W-1:0] pick_find_offset();
        int total;
        int base;
        int k;
        int sz;
        int roll;
        total = 0;
        foreach (live_sizes[n])
            total += live_sizes[n];
        roll = $urandom_range(0, 99);
        if (live_sizes.size() == 0 || roll >= 85) begin
            if (roll < 90)
                return OFFSET_W'(total);
            else if (roll < 95)
                return OFFSET_W'(total + $urandom_range(1, 1000));
            else
                return OFFSET_W'($urandom());
        end
        k    = $urandom_range(0, live_sizes.size() - 1);
        base = 0;
        for (int n = 0; n < k; n++)
            base += live_sizes[n];
        sz   = live_sizes[k];
        roll = $urandom_range(0, 99);
        if (sz == 0 || roll < 20)
            return OFFSET_W'(base);
        else if (roll < 40)
            return OFFSET_W'(base + sz - 1);
        else
            return OFFSET_W'(base + $urandom_range(0, sz - 1));
    endfunction

    // presents one beat and returns at the edge that accepts it
    task automatic send_beat(input logic op, input logic [HANDLE_BITS-1:0] handle,
                             input logic [LEN_BITS-1:0] size,
                             input logic [OFFSET_W-1:0] offset);
        while (allow_gaps && $urandom_range(0, 99) < 29) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_op           <= op;
        i_entry_handle <= handle;
        i_entry_size   <= size;
        i_char_offset  <= offset;
        do @(posedge i_clk); while (busy);
        if (op == OP_ADD) begin
            live_sizes.push_back(int'(size));
            if (live_sizes.size() > DEPTH)
                void'(live_sizes.pop_front());
        end
    endtask

    initial begin
        logic op;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_op           <= OP_ADD;
        i_entry_handle <= '0;
        i_entry_size   <= '0;
        i_char_offset  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty ring, then a zero-length entry that no find may report
        send_beat(OP_FIND, '1, '1, 20'hFFFFF);
        send_beat(OP_ADD, '0, '0, '0);
        send_beat(OP_FIND, '0, '0, '0);
        // widest entry: first byte, last byte, one past the end
        send_beat(OP_ADD, '1, '1, '1);
        send_beat(OP_FIND, '0, '0, '0);
        send_beat(OP_FIND, '0, '0, 20'd65534);
        send_beat(OP_FIND, '0, '0, 20'd65535);
        send_beat(OP_FIND, '0, '0, 20'hFFFFF);
        // fill the ring and push one past full so the oldest is dropped
        for (int n = 0; n < 15; n++)
            send_beat(OP_ADD, HANDLE_BITS'(32'hA5A5_0000 + n), LEN_BITS'(2), '0);
        send_beat(OP_FIND, '0, '0, '0);
        send_beat(OP_FIND, '0, '0, 20'd65535);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            allow_gaps = !(n >= 250 && n < 400);
            op = ($urandom_range(0, 99) < 35) ? OP_ADD : OP_FIND;
            send_beat(op, HANDLE_BITS'($urandom()), pick_entry_size(),
                      (op == OP_FIND) ? pick_find_offset() : OFFSET_W'($urandom()));
        end
        start <= 1'b0;

        do @(posedge i_clk); while (n_awaited != 0);
        repeat (DEPTH + 4) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> entry_ring_offset_lookup.f
src/erol_pkg.sv
src/entry_ring_offset_lookup.sv
bench/erol_lookup_checker.sv
bench/entry_ring_offset_lookup_tb.sv
